/* rtl/mdps_pkg.sv */
// ----------------------------------------------------------------------------
// mdps_pkg
// Shared types and constants of the minimum distance point selector.
// ----------------------------------------------------------------------------
package mdps_pkg;

	// Configuration register indexes
	localparam logic CfgMinSep  = 1'b0;
	localparam logic CfgMaxKeep = 1'b1;

	// Field widths fixed by the item format
	localparam int unsigned CoordW = 16;
	localparam int unsigned CountW = 6;
	localparam int unsigned Dist2W = 2 * CoordW;

	// Reset values of the configuration registers
	localparam logic [CoordW-1:0] MinSepReset  = 16'd480;
	localparam logic [CountW-1:0] MaxKeepReset = 6'd20;

	// Controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DONE
	} ctrl_state_t;

	// One compare result leaving the distance pipeline
	typedef struct packed {
		logic vld;
		logic last;
		logic near;
	} dist_res_t;

endpackage

/* rtl/mdps_if.sv */
// ----------------------------------------------------------------------------
// mdps_in_if / mdps_out_if
// Valid/ready channels for candidate points and for selection results.
// ----------------------------------------------------------------------------
interface mdps_in_if;
	logic        valid;
	logic        ready;
	logic        first_of_list;
	logic [15:0] pos_x;
	logic [15:0] pos_y;

	modport source (output valid, output first_of_list, output pos_x, output pos_y,
		input ready);
	modport sink (input valid, input first_of_list, input pos_x, input pos_y,
		output ready);
endinterface

interface mdps_out_if;
	logic       valid;
	logic       ready;
	logic       accepted;
	logic [5:0] kept_total;
	logic       set_full;

	modport source (output valid, output accepted, output kept_total, output set_full,
		input ready);
	modport sink (input valid, input accepted, input kept_total, input set_full,
		output ready);
endinterface

/* rtl/mdps_point_mem.sv */
// ----------------------------------------------------------------------------
// mdps_point_mem
// Kept point store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module mdps_point_mem
	import mdps_pkg::*;
#(
	parameter int unsigned DEPTH = 32,
	parameter int unsigned AW    = 5
) (
	input  logic                clk,
	input  logic                wr_en,
	input  logic [AW-1:0]       wr_addr,
	input  logic [Dist2W-1:0]   wr_data,
	input  logic [AW-1:0]       rd_addr,
	output logic [Dist2W-1:0]   rd_data
);

	logic [Dist2W-1:0] mem [DEPTH];
	logic [Dist2W-1:0] rd_data_q;

	// Write a kept point as {x, y}
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read: data follows the address in the next cycle
	always_ff @(posedge clk) begin
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

/* rtl/mdps_dist_unit.sv */
// ----------------------------------------------------------------------------
// mdps_dist_unit
// Three-stage squared distance compare of the candidate against one kept point.
// ----------------------------------------------------------------------------
module mdps_dist_unit
	import mdps_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_vld,
	input  logic              in_last,
	input  logic [Dist2W-1:0] kept_xy,
	input  logic [CoordW-1:0] cand_x,
	input  logic [CoordW-1:0] cand_y,
	input  logic [Dist2W-1:0] lim2,
	output dist_res_t         res
);

	logic [CoordW-1:0] kx;
	logic [CoordW-1:0] ky;
	logic [CoordW-1:0] dx_s1, dy_s1;
	logic [Dist2W-1:0] sqx_s2, sqy_s2;
	logic              near_s3;
	logic [2:0]        vld_q;
	logic [2:0]        last_q;

	assign kx = kept_xy[Dist2W-1:CoordW];
	assign ky = kept_xy[CoordW-1:0];

	// Advance the tag bits alongside the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			last_q <= '0;
		end else begin
			vld_q  <= {vld_q[1:0], in_vld};
			last_q <= {last_q[1:0], in_last};
		end
	end

	// Absolute differences
	always_ff @(posedge clk) begin
		dx_s1 <= (cand_x >= kx) ? (cand_x - kx) : (kx - cand_x);
		dy_s1 <= (cand_y >= ky) ? (cand_y - ky) : (ky - cand_y);
	end

	// Squares
	always_ff @(posedge clk) begin
		sqx_s2 <= Dist2W'(dx_s1) * Dist2W'(dx_s1);
		sqy_s2 <= Dist2W'(dy_s1) * Dist2W'(dy_s1);
	end

	// Sum and compare against the squared minimum separation
	always_ff @(posedge clk) begin
		near_s3 <= ({1'b0, sqx_s2} + {1'b0, sqy_s2}) < {1'b0, lim2};
	end

	assign res.vld  = vld_q[2];
	assign res.last = last_q[2];
	assign res.near = near_s3;

endmodule

/* rtl/mdps_ctrl.sv */
// ----------------------------------------------------------------------------
// mdps_ctrl
// Sequencer: walks the kept points, collects compare results, updates the
// kept set and holds the result for transfer.
// ----------------------------------------------------------------------------
module mdps_ctrl
	import mdps_pkg::*;
#(
	parameter int unsigned AW = 5
) (
	input  logic              clk,
	input  logic              arst_n,
	mdps_in_if.sink           in_ch,
	mdps_out_if.source        out_ch,
	input  logic [CountW-1:0] keep_lim,
	input  dist_res_t         dres,
	output logic              rd_vld,
	output logic              rd_last,
	output logic [AW-1:0]     rd_addr,
	output logic              wr_en,
	output logic [AW-1:0]     wr_addr,
	output logic [Dist2W-1:0] wr_data,
	output logic [CoordW-1:0] cand_x,
	output logic [CoordW-1:0] cand_y
);

	// Index width covering both the count and the memory address
	localparam int unsigned IW = (AW > CountW) ? AW : CountW;

	ctrl_state_t       state_q, state_n;
	logic [CountW-1:0] count_q, count_n;
	logic [CountW-1:0] rd_idx_q, rd_idx_n;
	logic              near_q, near_n;
	logic [CoordW-1:0] x_q, y_q;
	logic              res_acc_q, res_acc_n;
	logic [CountW-1:0] res_total_q, res_total_n;
	logic              res_full_q, res_full_n;
	logic              rd_vld_q, rd_last_q;
	logic              out_vld_q;
	logic              out_acc_q;
	logic [CountW-1:0] out_total_q;
	logic              out_full_q;
	logic              in_xfer;
	logic              out_load;
	logic              issue;
	logic              issue_last;
	logic [CountW-1:0] count_in;
	logic [CountW-1:0] wr_idx;
	logic              near_all;

	assign in_ch.ready = (state_q == ST_IDLE);
	assign in_xfer     = in_ch.valid && in_ch.ready;
	assign count_in    = in_ch.first_of_list ? '0 : count_q;
	assign issue       = (state_q == ST_SCAN);
	assign issue_last  = (rd_idx_q == (count_q - 1'b1));
	assign near_all    = near_q || dres.near;
	assign out_load    = (state_q == ST_DONE) && (!out_vld_q || out_ch.ready);

	// Next state, kept count and memory write
	always_comb begin
		state_n     = state_q;
		count_n     = count_q;
		rd_idx_n    = rd_idx_q;
		near_n      = near_q;
		res_acc_n   = res_acc_q;
		res_total_n = res_total_q;
		res_full_n  = res_full_q;
		wr_en       = 1'b0;
		wr_idx      = count_q;
		wr_data     = {x_q, y_q};
		case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					count_n  = count_in;
					rd_idx_n = '0;
					near_n   = 1'b0;
					if (count_in >= keep_lim) begin
						// set full: reject without a scan
						res_acc_n   = 1'b0;
						res_total_n = count_in;
						res_full_n  = 1'b1;
						state_n     = ST_DONE;
					end else if (count_in == '0) begin
						// empty set: keep the point at once
						wr_en       = 1'b1;
						wr_idx      = '0;
						wr_data     = {in_ch.pos_x, in_ch.pos_y};
						count_n     = 6'd1;
						res_acc_n   = 1'b1;
						res_total_n = 6'd1;
						res_full_n  = (6'd1 >= keep_lim);
						state_n     = ST_DONE;
					end else begin
						state_n = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				rd_idx_n = rd_idx_q + 1'b1;
				// fold in compares that come back while the walk goes on
				if (dres.vld) begin
					near_n = near_all;
				end
				if (issue_last) begin
					state_n = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (dres.vld) begin
					near_n = near_all;
					if (dres.last) begin
						if (near_all) begin
							res_acc_n   = 1'b0;
							res_total_n = count_q;
							res_full_n  = (count_q >= keep_lim);
						end else begin
							wr_en       = 1'b1;
							count_n     = count_q + 1'b1;
							res_acc_n   = 1'b1;
							res_total_n = count_q + 1'b1;
							res_full_n  = ((count_q + 1'b1) >= keep_lim);
						end
						state_n = ST_DONE;
					end
				end
			end
			ST_DONE: begin
				if (out_load) begin
					state_n = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	assign wr_addr = AW'(IW'(wr_idx));
	assign rd_addr = AW'(IW'(rd_idx_q));

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			rd_idx_q  <= '0;
			near_q    <= 1'b0;
			rd_vld_q  <= 1'b0;
			rd_last_q <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			state_q   <= state_n;
			count_q   <= count_n;
			rd_idx_q  <= rd_idx_n;
			near_q    <= near_n;
			rd_vld_q  <= issue;
			rd_last_q <= issue && issue_last;
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// Candidate and result payload
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			x_q <= in_ch.pos_x;
			y_q <= in_ch.pos_y;
		end
		res_acc_q   <= res_acc_n;
		res_total_q <= res_total_n;
		res_full_q  <= res_full_n;
		if (out_load) begin
			out_acc_q   <= res_acc_q;
			out_total_q <= res_total_q;
			out_full_q  <= res_full_q;
		end
	end

	assign rd_vld            = rd_vld_q;
	assign rd_last           = rd_last_q;
	assign cand_x            = x_q;
	assign cand_y            = y_q;
	assign out_ch.valid      = out_vld_q;
	assign out_ch.accepted   = out_acc_q;
	assign out_ch.kept_total = out_total_q;
	assign out_ch.set_full   = out_full_q;

endmodule

/* rtl/min_distance_point_selector_core.sv */
// ----------------------------------------------------------------------------
// min_distance_point_selector_core
// Greedy minimum distance feature suppression over a memory of kept points.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                               | handshake
//  in_ch    | in  | first_of_list, pos_x[15:0], pos_y      | valid/ready
//  out_ch   | out | accepted, kept_total[5:0], set_full    | valid/ready
//  cfg      | in  | cfg_index (0 min_separation, 1 max_keep), cfg_wdata[15:0] | cfg_we
//
// A point with kept points before it is compared against each of them in
// turn before its result shows; an empty or full set skips the scan. The
// next point can transfer once the result is loaded for output. The memory
// read port walks one kept point per cycle, followed by a compare pipeline drain.
// Reset clears the kept count and restores the configuration defaults; memory
// contents are not cleared. A result held by a stalled sink blocks the next
// point only after that point has finished.
// ----------------------------------------------------------------------------
module min_distance_point_selector_core
	import mdps_pkg::*;
#(
	parameter int unsigned MAX_KEPT = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	mdps_in_if.sink     in_ch,
	mdps_out_if.source  out_ch,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_wdata
);

	localparam int unsigned AW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
	localparam logic [8:0]  MaxKeptW = 9'(MAX_KEPT);

	logic [CoordW-1:0] min_sep_q;
	logic [CountW-1:0] max_keep_q;
	logic [Dist2W-1:0] lim2_q;
	logic [8:0]        lim_raw;
	logic [CountW-1:0] keep_lim;
	dist_res_t         dres;
	logic              rd_vld, rd_last;
	logic [AW-1:0]     rd_addr;
	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	logic [Dist2W-1:0] wr_data;
	logic [Dist2W-1:0] rd_data;
	logic [CoordW-1:0] cand_x, cand_y;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_sep_q  <= MinSepReset;
			max_keep_q <= MaxKeepReset;
		end else if (cfg_we) begin
			case (cfg_index)
				CfgMinSep:  min_sep_q  <= cfg_wdata;
				CfgMaxKeep: max_keep_q <= cfg_wdata[CountW-1:0];
				default: ;
			endcase
		end
	end

	// Register the square of the minimum separation for the compare
	always_ff @(posedge clk) begin
		lim2_q <= Dist2W'(min_sep_q) * Dist2W'(min_sep_q);
	end

	// Clamp the limit into 1 .. MAX_KEPT
	always_comb begin
		lim_raw = (max_keep_q == '0) ? 9'd1 : {3'b000, max_keep_q};
		if (lim_raw > MaxKeptW) begin
			lim_raw = MaxKeptW;
		end
	end
	assign keep_lim = lim_raw[CountW-1:0];

	mdps_ctrl #(
		.AW (AW)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.out_ch   (out_ch),
		.keep_lim (keep_lim),
		.dres     (dres),
		.rd_vld   (rd_vld),
		.rd_last  (rd_last),
		.rd_addr  (rd_addr),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.cand_x   (cand_x),
		.cand_y   (cand_y)
	);

	mdps_point_mem #(
		.DEPTH (MAX_KEPT),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	mdps_dist_unit u_dist (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (rd_vld),
		.in_last (rd_last),
		.kept_xy (rd_data),
		.cand_x  (cand_x),
		.cand_y  (cand_y),
		.lim2    (lim2_q),
		.res     (dres)
	);

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the minimum distance point selector against a cycle-free predictor.
// Points go in through a bursty sender. Every result is compared field by
// field with the predicted one, and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb_top;
	import mdps_pkg::*;

	localparam int unsigned MAX_KEPT    = 32;
	localparam int          SETTLE_CYC  = MAX_KEPT + 8;
	localparam int          DRAIN_LIMIT = 20000;
	localparam int          CYCLE_LIMIT = 400000;

	// One selection result
	typedef struct {
		logic       accepted;
		logic [5:0] kept_total;
		logic       set_full;
	} sel_result_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_index;
	logic [15:0] cfg_wdata;

	mdps_in_if  pts_if ();
	mdps_out_if sel_if ();

	min_distance_point_selector_core #(
		.MAX_KEPT(MAX_KEPT)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (pts_if),
		.out_ch   (sel_if),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	// Predictor state: configuration and the kept point set
	logic [15:0]  sep_cfg;
	logic [5:0]   keep_cfg;
	logic [15:0]  kept_x [MAX_KEPT];
	logic [15:0]  kept_y [MAX_KEPT];
	int unsigned  kept_n;

	sel_result_t  pending_results [$];
	int           fault_count;
	int           cycle_count;
	int           burst_left;
	int           points_sent;
	int           results_seen;
	int           accept_count;
	int           full_reject_count;
	int           list_count;

	// Receiver stall pattern
	logic [15:0]  ready_pat;
	int           pat_pos;
	int           pat_life;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycle_count);
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic report_fault(input string what);
		fault_count++;
		$display("MISMATCH @%0t: %s", $time, what);
	endtask

	// Greedy selection of one point against the kept set
	task automatic judge_point(input logic first, input logic [15:0] x,
		input logic [15:0] y, output sel_result_t res);
		int unsigned     lim;
		longint unsigned lim2;
		longint          dx;
		longint          dy;
		bit              far;
		if (first)
			kept_n = 0;
		lim = 32'(keep_cfg);
		if (lim < 1)
			lim = 1;
		if (lim > MAX_KEPT)
			lim = MAX_KEPT;
		lim2 = longint'(sep_cfg) * longint'(sep_cfg);
		far = 1'b1;
		for (int i = 0; i < kept_n; i++) begin
			dx = longint'(x) - longint'(kept_x[i]);
			dy = longint'(y) - longint'(kept_y[i]);
			if (dx < 0)
				dx = -dx;
			if (dy < 0)
				dy = -dy;
			if (longint'(dx * dx + dy * dy) < longint'(lim2))
				far = 1'b0;
		end
		res.accepted = 1'b0;
		if (kept_n < lim && far) begin
			kept_x[kept_n] = x;
			kept_y[kept_n] = y;
			kept_n++;
			res.accepted = 1'b1;
		end
		res.kept_total = kept_n[5:0];
		res.set_full   = (kept_n >= lim);
	endtask

	// Send one point, with a random gap at the end of each burst
	task automatic send_point(input logic first, input logic [15:0] x, input logic [15:0] y);
		sel_result_t res;
		int          gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			if (gap > 0) begin
				@(negedge clk);
				pts_if.valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		burst_left--;
		@(negedge clk);
		pts_if.valid         <= 1'b1;
		pts_if.first_of_list <= first;
		pts_if.pos_x         <= x;
		pts_if.pos_y         <= y;
		do
			@(posedge clk);
		while (!pts_if.ready);
		judge_point(first, x, y, res);
		pending_results.insert(pending_results.size(), res);
		points_sent++;
		if (first)
			list_count++;
	endtask

	// Hold off until every result is back and the core has settled
	task automatic wait_idle();
		@(negedge clk);
		pts_if.valid <= 1'b0;
		for (int w = 0; w < DRAIN_LIMIT && pending_results.size() != 0; w++)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
		burst_left = 0;
	endtask

	task automatic write_cfg(input logic idx, input logic [15:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(negedge clk);
		cfg_we    <= 1'b0;
		if (idx == CfgMinSep)
			sep_cfg = data;
		else
			keep_cfg = data[5:0];
	endtask

	function automatic logic [15:0] clamp_coord(input int v);
		if (v < 0)
			return 16'd0;
		if (v > 65535)
			return 16'hFFFF;
		return v[15:0];
	endfunction

	// Pick a point: mostly near a kept one, sometimes exactly at the minimum, else anywhere
	task automatic make_point(output logic first, output logic [15:0] x, output logic [15:0] y);
		int k;
		int sel;
		int span;
		int ox;
		int oy;
		first = ($urandom_range(0, 11) == 0);
		sel   = $urandom_range(0, 9);
		if (kept_n != 0 && sel < 7) begin
			k    = $urandom_range(0, kept_n - 1);
			span = 2 * int'(sep_cfg) + 2;
			if (span > 65535)
				span = 65535;
			if (sel == 0) begin
				ox = int'(sep_cfg);
				oy = 0;
				if ($urandom_range(0, 1))
					ox = -ox;
				if ($urandom_range(0, 1)) begin
					oy = ox;
					ox = 0;
				end
			end else begin
				ox = int'($urandom_range(0, 2 * span)) - span;
				oy = int'($urandom_range(0, 2 * span)) - span;
			end
			x = clamp_coord(int'(kept_x[k]) + ox);
			y = clamp_coord(int'(kept_y[k]) + oy);
		end else begin
			x = 16'($urandom);
			y = 16'($urandom);
		end
	endtask

	// Check each result transfer against the oldest prediction
	always @(posedge clk) begin
		sel_result_t want;
		if (arst_n && sel_if.valid && sel_if.ready) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				report_fault("result with nothing predicted");
			end else begin
				want = pending_results.pop_front();
				if (sel_if.accepted !== want.accepted)
					report_fault($sformatf("accepted %b, want %b",
						sel_if.accepted, want.accepted));
				if (sel_if.kept_total !== want.kept_total)
					report_fault($sformatf("kept_total %0d, want %0d",
						sel_if.kept_total, want.kept_total));
				if (sel_if.set_full !== want.set_full)
					report_fault($sformatf("set_full %b, want %b",
						sel_if.set_full, want.set_full));
				if (want.accepted)
					accept_count++;
				else if (want.set_full)
					full_reject_count++;
			end
		end
	end

	// Stall the receiver on a rotating pattern, sometimes not at all
	always @(negedge clk) begin
		if (pat_life == 0) begin
			ready_pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
			pat_life  = $urandom_range(16, 96);
		end
		pat_life--;
		sel_if.ready <= ready_pat[pat_pos];
		pat_pos = (pat_pos + 1) % 16;
	end

	// Reset configuration, equal distance and far corners
	task automatic test_reset_defaults();
		send_point(1'b1, 16'd0, 16'd0);
		send_point(1'b0, 16'hFFFF, 16'hFFFF);
		send_point(1'b0, 16'd479, 16'd0);
		send_point(1'b0, 16'd480, 16'd0);
		send_point(1'b0, 16'hFFFF, 16'hFF9B);
		send_point(1'b1, 16'd0, 16'd0);
	endtask

	// Squared distance equal to the squared minimum is kept
	task automatic test_exact_boundary();
		wait_idle();
		write_cfg(CfgMinSep, 16'd5);
		send_point(1'b1, 16'd100, 16'd100);
		send_point(1'b0, 16'd103, 16'd104);
		send_point(1'b0, 16'd97, 16'd97);
		send_point(1'b0, 16'd96, 16'd97);
		wait_idle();
		write_cfg(CfgMinSep, 16'hFFFF);
		send_point(1'b1, 16'd0, 16'd0);
		send_point(1'b0, 16'hFFFF, 16'd0);
		send_point(1'b0, 16'hFFFF, 16'hFFFF);
		send_point(1'b0, 16'h8000, 16'h8000);
	endtask

	// Zero separation keeps duplicates until full
	task automatic test_zero_separation();
		wait_idle();
		write_cfg(CfgMinSep, 16'd0);
		write_cfg(CfgMaxKeep, 16'd3);
		send_point(1'b1, 16'd5, 16'd5);
		repeat (3) send_point(1'b0, 16'd5, 16'd5);
	endtask

	// A limit of zero acts as one
	task automatic test_limit_extremes();
		wait_idle();
		write_cfg(CfgMaxKeep, 16'd0);
		send_point(1'b1, 16'd1, 16'd1);
		send_point(1'b0, 16'd9000, 16'd9000);
	endtask

	// Lower the limit below the kept count in the middle of a list
	task automatic test_limit_lowered();
		wait_idle();
		write_cfg(CfgMaxKeep, 16'd10);
		send_point(1'b1, 16'd10, 16'd20);
		send_point(1'b0, 16'd30, 16'd40);
		send_point(1'b0, 16'd50, 16'd60);
		send_point(1'b0, 16'd70, 16'd80);
		wait_idle();
		write_cfg(CfgMaxKeep, 16'd2);
		send_point(1'b0, 16'd900, 16'd900);
	endtask

	task automatic run_random_phase(input logic [15:0] sep, input logic [5:0] keep,
		input int n_items);
		logic        first;
		logic [15:0] x;
		logic [15:0] y;
		wait_idle();
		write_cfg(CfgMinSep, sep);
		write_cfg(CfgMaxKeep, {10'd0, keep});
		for (int i = 0; i < n_items; i++) begin
			make_point(first, x, y);
			send_point(first, x, y);
		end
	endtask

	// Random lists under a spread of settings, the extremes among them
	task automatic test_random();
		run_random_phase(16'd480, 6'd20, 64);
		run_random_phase(16'd0, 6'd63, 64);
		run_random_phase(16'hFFFF, 6'd32, 64);
		run_random_phase(16'($urandom_range(16, 200)), 6'd32, 64);
		run_random_phase(16'($urandom), 6'($urandom_range(1, 32)), 64);
		run_random_phase(16'd64, 6'd1, 64);
		run_random_phase(16'($urandom_range(0, 4000)), 6'($urandom_range(0, 63)), 64);
	endtask

	initial begin
		arst_n               = 1'b0;
		cfg_we               = 1'b0;
		cfg_index            = CfgMinSep;
		cfg_wdata            = 16'd0;
		pts_if.valid         = 1'b0;
		pts_if.first_of_list = 1'b0;
		pts_if.pos_x         = 16'd0;
		pts_if.pos_y         = 16'd0;
		sel_if.ready         = 1'b0;
		ready_pat            = 16'hFFFF;
		pat_pos              = 0;
		pat_life             = 0;
		cycle_count          = 0;
		fault_count          = 0;
		burst_left           = 0;
		points_sent          = 0;
		results_seen         = 0;
		accept_count         = 0;
		full_reject_count    = 0;
		list_count           = 0;
		sep_cfg              = MinSepReset;
		keep_cfg             = MaxKeepReset;
		kept_n               = 0;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_defaults();
		test_exact_boundary();
		test_zero_separation();
		test_limit_extremes();
		test_limit_lowered();
		test_random();

		wait_idle();
		if (pending_results.size() != 0)
			report_fault($sformatf("%0d results never arrived", pending_results.size()));

		$display("Sent %0d points in %0d lists; %0d results checked",
			points_sent, list_count, results_seen);
		$display("%0d kept, %0d turned away by a full set, %0d mismatches",
			accept_count, full_reject_count, fault_count);
		if (fault_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
